[rtl/rail_current_averaging_monitor_defines.svh]
// assertion macros for the rail current averaging monitor
// expects signals named clock and reset in the module that uses them
`ifndef RAIL_CURRENT_AVERAGING_MONITOR_DEFINES_SVH
`define RAIL_CURRENT_AVERAGING_MONITOR_DEFINES_SVH

// same-cycle implication
`define RCAM_ASSERT_IMP(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rcam same-cycle check failed");

// next-cycle implication
`define RCAM_ASSERT_NXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rcam next-cycle check failed");

`endif

[rtl/rcam_pkg.sv]
// shared types, widths and codes of the rail current averaging monitor
// no dependencies
package rcam_pkg;

   localparam int ADC_BITS = 12;
   localparam int SUM_BITS = 32;

   localparam int THR_W   = 12;
   localparam int SCALE_W = 11;
   localparam int OFS_W   = 16;
   localparam int MA_W    = OFS_W;
   localparam int CNT_W   = 32;
   localparam int AVG_W   = 32;
   localparam int CMD_W   = 8;
   localparam int KIND_W  = 2;
   localparam int LEN_W   = 3;
   localparam int CSR_IDX_W = 2;

   localparam int RAILS  = 3;
   localparam int RAIL_W = 2;

   // divide by 1000 as multiply by a rounded-up reciprocal, exact for PROD_W-bit products
   localparam int PROD_W     = SCALE_W + ADC_BITS;
   localparam int RECIP_SH   = PROD_W + 10;
   localparam int RECIP_M_W  = RECIP_SH - 9;
   localparam int RECIP_W    = PROD_W + RECIP_M_W;
   localparam int QUO_W      = PROD_W - 9;
   localparam logic [63:0] RECIP_M = ((64'd1 << RECIP_SH) + 64'd999) / 64'd1000;

   localparam int STEP_W = $clog2(SUM_BITS);

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic MODE_SAMPLE = 1'b0;

   localparam logic [CMD_W-1:0] CMD_STATUS  = 8'h01;
   localparam logic [CMD_W-1:0] CMD_AVG_3V3 = 8'h02;
   localparam logic [CMD_W-1:0] CMD_AVG_5V  = 8'h03;
   localparam logic [CMD_W-1:0] CMD_AVG_12V = 8'h04;

   localparam logic [RAIL_W-1:0] RAIL_12V  = 2'd0;
   localparam logic [RAIL_W-1:0] RAIL_5V   = 2'd1;
   localparam logic [RAIL_W-1:0] RAIL_3V3  = 2'd2;
   localparam logic [RAIL_W-1:0] RAIL_LAST = RAIL_3V3;

   localparam logic [KIND_W-1:0] KIND_STATUS = 2'd0;
   localparam logic [KIND_W-1:0] KIND_AVG    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_EMPTY  = 2'd2;

   localparam logic [LEN_W-1:0] LEN_STATUS = 3'd1;
   localparam logic [LEN_W-1:0] LEN_WORD   = 3'd4;

   localparam logic [AVG_W-1:0] EMPTY_MARK = 32'd69;

   localparam logic [CSR_IDX_W-1:0] REG_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SCALE     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_OFFSET    = 2'd2;

   localparam logic [THR_W-1:0]   THRESHOLD_RESET = 12'd500;
   localparam logic [SCALE_W-1:0] SCALE_RESET     = 11'd805;
   localparam logic [OFS_W-1:0]   OFFSET_RESET    = 16'd3298;

   typedef enum logic [1:0] {
      OP_SAMPLE,
      OP_STATUS,
      OP_AVG
   } rcam_op_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_MUL,
      BK_RECIP,
      BK_ACC,
      BK_CHECK,
      BK_DIV,
      BK_REPLY
   } rcam_state_type;

   typedef struct packed {
      rcam_op_type                         op;
      logic [RAIL_W-1:0]                   rail;
      logic [RAILS-1:0][ADC_BITS-1:0]      volt;
      logic [RAILS-1:0][ADC_BITS-1:0]      cur;
   } rcam_entry_type;

   typedef struct packed {
      logic [THR_W-1:0]   threshold;
      logic [SCALE_W-1:0] scale;
      logic [OFS_W-1:0]   offset;
   } rcam_cfg_type;

endpackage

[rtl/rcam_front.sv]
// front end: takes request beats, sorts them into sample / status / average work
// and drops unknown commands; depends on rcam_pkg
module rcam_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_mode,
   input  logic [rcam_pkg::CMD_W-1:0]    req_command_code,
   input  logic [rcam_pkg::ADC_BITS-1:0] req_volt_raw_12v,
   input  logic [rcam_pkg::ADC_BITS-1:0] req_volt_raw_5v,
   input  logic [rcam_pkg::ADC_BITS-1:0] req_volt_raw_3v3,
   input  logic [rcam_pkg::ADC_BITS-1:0] req_cur_raw_12v,
   input  logic [rcam_pkg::ADC_BITS-1:0] req_cur_raw_5v,
   input  logic [rcam_pkg::ADC_BITS-1:0] req_cur_raw_3v3,
   output logic                          push,
   output rcam_pkg::rcam_entry_type      push_entry,
   input  logic                          q_full
);
   import rcam_pkg::*;

   logic           fr_valid_ff, fr_valid_in;
   rcam_entry_type fr_entry_ff, fr_entry_in;
   logic           keep;
   logic           accept;

   always_comb begin
      fr_entry_in = '0;
      keep = 1'b1;
      fr_entry_in.volt[RAIL_12V] = req_volt_raw_12v;
      fr_entry_in.volt[RAIL_5V]  = req_volt_raw_5v;
      fr_entry_in.volt[RAIL_3V3] = req_volt_raw_3v3;
      fr_entry_in.cur[RAIL_12V]  = req_cur_raw_12v;
      fr_entry_in.cur[RAIL_5V]   = req_cur_raw_5v;
      fr_entry_in.cur[RAIL_3V3]  = req_cur_raw_3v3;
      if (req_mode == MODE_SAMPLE) begin
         fr_entry_in.op   = OP_SAMPLE;
         fr_entry_in.rail = RAIL_12V;
      end else begin
         case (req_command_code)
            CMD_STATUS: begin
               fr_entry_in.op   = OP_STATUS;
               fr_entry_in.rail = RAIL_12V;
            end
            CMD_AVG_3V3: begin
               fr_entry_in.op   = OP_AVG;
               fr_entry_in.rail = RAIL_3V3;
            end
            CMD_AVG_5V: begin
               fr_entry_in.op   = OP_AVG;
               fr_entry_in.rail = RAIL_5V;
            end
            CMD_AVG_12V: begin
               fr_entry_in.op   = OP_AVG;
               fr_entry_in.rail = RAIL_12V;
            end
            default: begin
               // unknown command: swallowed here, nothing reaches the back end
               keep = 1'b0;
            end
         endcase
      end
   end

   assign req_stall = fr_valid_ff && q_full;
   assign accept    = req_valid && !req_stall;
   assign push      = fr_valid_ff && !q_full;
   assign push_entry = fr_entry_ff;

   always_comb begin
      if (req_stall) begin
         fr_valid_in = fr_valid_ff;
      end else begin
         fr_valid_in = accept && keep;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fr_valid_ff <= 1'b0;
      end else begin
         fr_valid_ff <= fr_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         fr_entry_ff <= fr_entry_in;
      end
   end

endmodule

[rtl/rcam_queue.sv]
// short work queue between front and back end
// depends on rcam_pkg
module rcam_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  rcam_pkg::rcam_entry_type push_entry,
   output logic                     full,
   input  logic                     pop,
   output logic                     head_valid,
   output rcam_pkg::rcam_entry_type head_entry
);
   import rcam_pkg::*;

   rcam_entry_type      slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push;
   logic                do_pop;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = slot_ff[rd_ptr_ff];

   assign do_push = push && !full;
   assign do_pop  = pop && head_valid;

   // depth is a power of two, so the pointers wrap by themselves
   assign wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
   assign rd_ptr_in = do_pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

[rtl/rcam_back.sv]
// back end: current conversion and accumulation, serial average divider,
// reply register; depends on rcam_pkg and the assertion macro header
`include "rail_current_averaging_monitor_defines.svh"

module rcam_back (
   input  logic                        clock,
   input  logic                        reset,
   input  rcam_pkg::rcam_cfg_type      cfg,
   input  logic                        q_valid,
   input  rcam_pkg::rcam_entry_type    q_head,
   output logic                        q_pop,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [rcam_pkg::KIND_W-1:0] rsp_reply_kind,
   output logic                        rsp_rail_fault,
   output logic [rcam_pkg::AVG_W-1:0]  rsp_average_ma,
   output logic [rcam_pkg::LEN_W-1:0]  rsp_reply_length
);
   import rcam_pkg::*;

   rcam_state_type state_ff, state_in;
   logic [RAIL_W-1:0] rail_ff, rail_in;

   logic [ADC_BITS-1:0] volts_ff [RAILS];
   logic [SUM_BITS-1:0] sums_ff  [RAILS];
   logic [CNT_W-1:0]    cnts_ff  [RAILS];

   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [RECIP_W-1:0]  recip_ff, recip_in;
   logic [QUO_W-1:0]    quo_conv;
   logic [MA_W+QUO_W-1:0] ma_diff;
   logic [MA_W-1:0]     ma;

   logic [CNT_W-1:0]    rem_ff, rem_in;
   logic [SUM_BITS-1:0] quo_ff, quo_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [CNT_W:0]      rem_shift;
   logic [CNT_W:0]      den;
   logic                rem_ge;

   logic [SUM_BITS-1:0] sum_sel;
   logic [CNT_W-1:0]    cnt_sel;
   logic                cnt_zero;
   logic                fault;

   logic rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0] rsp_kind_ff, rsp_kind_in;
   logic              rsp_fault_ff, rsp_fault_in;
   logic [AVG_W-1:0]  rsp_avg_ff, rsp_avg_in;
   logic [LEN_W-1:0]  rsp_len_ff, rsp_len_in;
   logic              rsp_free;

   logic ld_volts, do_acc, div_init, div_step, ld_rsp, clr_rail;

   assign sum_sel  = sums_ff[rail_ff];
   assign cnt_sel  = cnts_ff[rail_ff];
   assign cnt_zero = (cnt_sel == '0);
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      fault = 1'b0;
      for (int i = 0; i < RAILS; i++) begin
         if ((ADC_BITS+THR_W)'(volts_ff[i]) < (ADC_BITS+THR_W)'(cfg.threshold)) begin
            fault = 1'b1;
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (q_valid) begin
               case (q_head.op)
                  OP_SAMPLE: state_in = BK_MUL;
                  OP_STATUS: state_in = BK_REPLY;
                  OP_AVG:    state_in = BK_CHECK;
                  default:   state_in = BK_IDLE;
               endcase
            end
         end
         BK_MUL:   state_in = BK_RECIP;
         BK_RECIP: state_in = BK_ACC;
         BK_ACC:   state_in = (rail_ff == RAIL_LAST) ? BK_IDLE : BK_MUL;
         BK_CHECK: state_in = cnt_zero ? BK_REPLY : BK_DIV;
         BK_DIV:   state_in = (step_ff == STEP_W'(SUM_BITS - 1)) ? BK_REPLY : BK_DIV;
         BK_REPLY: state_in = rsp_free ? BK_IDLE : BK_REPLY;
         default:  state_in = BK_IDLE;
      endcase
   end

   // controls
   always_comb begin
      ld_volts = 1'b0;
      do_acc   = 1'b0;
      div_init = 1'b0;
      div_step = 1'b0;
      ld_rsp   = 1'b0;
      q_pop    = 1'b0;
      case (state_ff)
         BK_IDLE:  ld_volts = q_valid && (q_head.op == OP_SAMPLE);
         BK_ACC: begin
            do_acc = 1'b1;
            q_pop  = (rail_ff == RAIL_LAST);
         end
         BK_CHECK: div_init = !cnt_zero;
         BK_DIV:   div_step = 1'b1;
         BK_REPLY: begin
            ld_rsp = rsp_free;
            q_pop  = rsp_free;
         end
         default: begin
         end
      endcase
      clr_rail = ld_rsp && (q_head.op == OP_AVG) && !cnt_zero;
   end

   always_comb begin
      rail_in = rail_ff;
      if (state_ff == BK_IDLE && q_valid) begin
         rail_in = (q_head.op == OP_AVG) ? q_head.rail : RAIL_12V;
      end else if (do_acc) begin
         rail_in = (rail_ff == RAIL_LAST) ? RAIL_12V : rail_ff + RAIL_W'(1);
      end
   end

   // current conversion: scale product, reciprocal product, then offset subtract
   assign prod_in  = PROD_W'(cfg.scale) * PROD_W'(q_head.cur[rail_ff]);
   assign recip_in = RECIP_W'(prod_ff) * RECIP_W'(RECIP_M[RECIP_M_W-1:0]);
   assign quo_conv = recip_ff[RECIP_SH +: QUO_W];
   assign ma_diff  = {{QUO_W{1'b0}}, cfg.offset} - {{MA_W{1'b0}}, quo_conv};
   assign ma       = ma_diff[MA_W-1:0];

   // restoring divider, one quotient bit per cycle
   assign den       = {1'b0, cnt_sel};
   assign rem_shift = {rem_ff, quo_ff[SUM_BITS-1]};
   assign rem_ge    = (rem_shift >= den);

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      step_in = step_ff;
      if (div_init) begin
         rem_in  = '0;
         quo_in  = sum_sel;
         step_in = '0;
      end else if (div_step) begin
         // the remainder stays below the count, so it fits the count width
         rem_in  = rem_ge ? CNT_W'(rem_shift - den) : rem_shift[CNT_W-1:0];
         quo_in  = {quo_ff[SUM_BITS-2:0], rem_ge};
         step_in = step_ff + STEP_W'(1);
      end
   end

   always_comb begin
      rsp_kind_in  = KIND_STATUS;
      rsp_fault_in = 1'b0;
      rsp_avg_in   = '0;
      rsp_len_in   = LEN_STATUS;
      case (q_head.op)
         OP_STATUS: begin
            rsp_fault_in = fault;
         end
         OP_AVG: begin
            rsp_len_in = LEN_WORD;
            if (cnt_zero) begin
               rsp_kind_in = KIND_EMPTY;
               rsp_avg_in  = EMPTY_MARK;
            end else begin
               rsp_kind_in = KIND_AVG;
               rsp_avg_in  = AVG_W'(quo_ff);
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid_in = ld_rsp ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rail_ff      <= RAIL_12V;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < RAILS; i++) begin
            volts_ff[i] <= '0;
            sums_ff[i]  <= '0;
            cnts_ff[i]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rail_ff      <= rail_in;
         rsp_valid_ff <= rsp_valid_in;
         if (ld_volts) begin
            for (int i = 0; i < RAILS; i++) begin
               volts_ff[i] <= q_head.volt[i];
            end
         end
         if (do_acc) begin
            sums_ff[rail_ff] <= sum_sel + SUM_BITS'(ma);
            cnts_ff[rail_ff] <= cnt_sel + CNT_W'(1);
         end else if (clr_rail) begin
            sums_ff[rail_ff] <= '0;
            cnts_ff[rail_ff] <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      recip_ff <= recip_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      step_ff  <= step_in;
      if (ld_rsp) begin
         rsp_kind_ff  <= rsp_kind_in;
         rsp_fault_ff <= rsp_fault_in;
         rsp_avg_ff   <= rsp_avg_in;
         rsp_len_ff   <= rsp_len_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_reply_kind   = rsp_kind_ff;
   assign rsp_rail_fault   = rsp_fault_ff;
   assign rsp_average_ma   = rsp_avg_ff;
   assign rsp_reply_length = rsp_len_ff;

   `RCAM_ASSERT_IMP(a_div_nonzero_den, state_ff == BK_DIV, cnt_sel != '0)
   `RCAM_ASSERT_IMP(a_pop_has_entry, q_pop, q_valid)
   `RCAM_ASSERT_NXT(a_pop_ends_item, q_pop, state_ff == BK_IDLE)
   `RCAM_ASSERT_IMP(a_len_matches_kind, rsp_valid_ff,
      (rsp_kind_ff == KIND_STATUS) == (rsp_len_ff == LEN_STATUS))

endmodule

[rtl/rail_current_averaging_monitor.sv]
// a sample beat walks the back end through all three rails, each a scale multiply,
// a reciprocal multiply for the divide by 1000 and an accumulate step
// status command: the front register, the queue, then the reply register; average command:
// also the count check and, for a non-empty rail, the one-bit-per-cycle restoring divider
// a two-entry queue lets the front take beats while the back end works or a reply waits
// synchronous reset clears all sums, counts, voltages and loads register defaults
module rail_current_averaging_monitor (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_mode,
   input  logic [rcam_pkg::CMD_W-1:0]     req_command_code,
   input  logic [rcam_pkg::ADC_BITS-1:0]  req_volt_raw_12v,
   input  logic [rcam_pkg::ADC_BITS-1:0]  req_volt_raw_5v,
   input  logic [rcam_pkg::ADC_BITS-1:0]  req_volt_raw_3v3,
   input  logic [rcam_pkg::ADC_BITS-1:0]  req_cur_raw_12v,
   input  logic [rcam_pkg::ADC_BITS-1:0]  req_cur_raw_5v,
   input  logic [rcam_pkg::ADC_BITS-1:0]  req_cur_raw_3v3,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [rcam_pkg::KIND_W-1:0]    rsp_reply_kind,
   output logic                           rsp_rail_fault,
   output logic [rcam_pkg::AVG_W-1:0]     rsp_average_ma,
   output logic [rcam_pkg::LEN_W-1:0]     rsp_reply_length,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [rcam_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [rcam_pkg::OFS_W-1:0]     csr_wdata
);
   import rcam_pkg::*;

   rcam_cfg_type   cfg_ff, cfg_in;
   logic           push;
   rcam_entry_type push_entry;
   logic           q_full;
   logic           q_pop;
   logic           q_valid;
   rcam_entry_type q_head;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_THRESHOLD: cfg_in.threshold = csr_wdata[THR_W-1:0];
            REG_SCALE:     cfg_in.scale     = csr_wdata[SCALE_W-1:0];
            REG_OFFSET:    cfg_in.offset    = csr_wdata[OFS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold <= THRESHOLD_RESET;
         cfg_ff.scale     <= SCALE_RESET;
         cfg_ff.offset    <= OFFSET_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rcam_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_command_code (req_command_code),
      .req_volt_raw_12v (req_volt_raw_12v),
      .req_volt_raw_5v  (req_volt_raw_5v),
      .req_volt_raw_3v3 (req_volt_raw_3v3),
      .req_cur_raw_12v  (req_cur_raw_12v),
      .req_cur_raw_5v   (req_cur_raw_5v),
      .req_cur_raw_3v3  (req_cur_raw_3v3),
      .push             (push),
      .push_entry       (push_entry),
      .q_full           (q_full)
   );

   rcam_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_entry (q_head)
   );

   rcam_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .q_valid          (q_valid),
      .q_head           (q_head),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_reply_kind   (rsp_reply_kind),
      .rsp_rail_fault   (rsp_rail_fault),
      .rsp_average_ma   (rsp_average_ma),
      .rsp_reply_length (rsp_reply_length)
   );

endmodule

[dv/testbench.sv]
// self-checking testbench for the rail current averaging monitor: directed and random
// sample and command beats, with an in-bench prediction of every reply
// depends on rcam_pkg and rail_current_averaging_monitor from the rtl folder
`timescale 1ns / 1ps

module testbench;
   import rcam_pkg::*;

   localparam logic                 MODE_COMMAND     = 1'b1;
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED       = 2'd3;
   localparam int                   MA_DIVISOR       = 1000;
   localparam int                   RANDOM_PER_PHASE = 200;
   localparam int                   PRESSURE_BEATS   = 40;
   localparam int                   HOLD_CYCLES      = 400;
   localparam int                   SETTLE_CYCLES    = 120;
   localparam int                   DRAIN_LIMIT      = 20000;
   localparam int                   REPORT_LIMIT     = 10;

   typedef struct packed {
      logic                           mode;
      logic [CMD_W-1:0]               code;
      logic [RAILS-1:0][ADC_BITS-1:0] volt;   // indexed by RAIL_*
      logic [RAILS-1:0][ADC_BITS-1:0] cur;
   } monitor_beat_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              fault;
      logic [AVG_W-1:0]  avg;
      logic [LEN_W-1:0]  len;
   } rail_reply_type;

   class rail_reply_tracker;
      logic [THR_W-1:0]    threshold;
      logic [SCALE_W-1:0]  scale;
      logic [OFS_W-1:0]    offset;
      logic [ADC_BITS-1:0] last_volt [RAILS];
      logic [SUM_BITS-1:0] rail_sum [RAILS];
      logic [CNT_W-1:0]    rail_count [RAILS];
      rail_reply_type      pending_replies [$];
      int mismatches, samples_seen, status_asked, averages_read, empty_reads, ignored_cmds;

      function new();
         threshold = THRESHOLD_RESET;
         scale     = SCALE_RESET;
         offset    = OFFSET_RESET;
         for (int r = 0; r < RAILS; r++) begin
            last_volt[r]  = '0;
            rail_sum[r]   = '0;
            rail_count[r] = '0;
         end
      endfunction

      function void flag(string what);
         mismatches++;
         if (mismatches <= REPORT_LIMIT) $display("[%0t] %s", $realtime, what);
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [OFS_W-1:0] data);
         case (idx)
            REG_THRESHOLD: threshold = data[THR_W-1:0];
            REG_SCALE:     scale     = data[SCALE_W-1:0];
            REG_OFFSET:    offset    = data;
            default: ;
         endcase
      endfunction

      function void read_rail(int r);
         if (rail_count[r] == '0) begin
            pending_replies.push_back('{KIND_EMPTY, 1'b0, EMPTY_MARK, LEN_WORD});
            empty_reads++;
         end else begin
            pending_replies.push_back('{KIND_AVG, 1'b0, AVG_W'(rail_sum[r] / rail_count[r]),
                                        LEN_WORD});
            rail_sum[r]   = '0;
            rail_count[r] = '0;
            averages_read++;
         end
      endfunction

      function void note_beat(monitor_beat_type b);
         logic [PROD_W-1:0] prod;
         logic [MA_W-1:0]   ma;
         logic              fault;
         if (b.mode == MODE_SAMPLE) begin
            for (int r = 0; r < RAILS; r++) begin
               last_volt[r]  = b.volt[r];
               prod          = PROD_W'(scale) * PROD_W'(b.cur[r]);
               // offset minus the scaled reading, wrapping at 16 bits
               ma            = offset - MA_W'(prod / MA_DIVISOR);
               rail_sum[r]   = rail_sum[r] + SUM_BITS'(ma);
               rail_count[r] = rail_count[r] + 1'b1;
            end
            samples_seen++;
            return;
         end
         case (b.code)
            CMD_STATUS: begin
               fault = 1'b0;
               for (int r = 0; r < RAILS; r++)
                  if (last_volt[r] < threshold) fault = 1'b1;
               pending_replies.push_back('{KIND_STATUS, fault, '0, LEN_STATUS});
               status_asked++;
            end
            CMD_AVG_3V3: read_rail(RAIL_3V3);
            CMD_AVG_5V:  read_rail(RAIL_5V);
            CMD_AVG_12V: read_rail(RAIL_12V);
            default:     ignored_cmds++;
         endcase
      endfunction

      function void check_reply(rail_reply_type got);
         rail_reply_type want;
         if (pending_replies.size() == 0) begin
            flag($sformatf("reply beat with none expected: kind %0d fault %0d avg %0d len %0d",
                           got.kind, got.fault, got.avg, got.len));
            return;
         end
         want = pending_replies.pop_front();
         if (got.kind !== want.kind || got.fault !== want.fault ||
             got.avg !== want.avg || got.len !== want.len)
            flag($sformatf({"reply mismatch: expected kind %0d fault %0d avg %0d len %0d,",
                            " got kind %0d fault %0d avg %0d len %0d"},
                           want.kind, want.fault, want.avg, want.len,
                           got.kind, got.fault, got.avg, got.len));
      endfunction
   endclass

   logic                   clock;
   logic                   reset            = 1'b1;
   logic                   req_valid        = 1'b0;
   logic                   req_stall;
   logic                   req_mode         = 1'b0;
   logic [CMD_W-1:0]       req_command_code = '0;
   logic [ADC_BITS-1:0]    req_volt_raw_12v = '0;
   logic [ADC_BITS-1:0]    req_volt_raw_5v  = '0;
   logic [ADC_BITS-1:0]    req_volt_raw_3v3 = '0;
   logic [ADC_BITS-1:0]    req_cur_raw_12v  = '0;
   logic [ADC_BITS-1:0]    req_cur_raw_5v   = '0;
   logic [ADC_BITS-1:0]    req_cur_raw_3v3  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall        = 1'b0;
   logic [KIND_W-1:0]      rsp_reply_kind;
   logic                   rsp_rail_fault;
   logic [AVG_W-1:0]       rsp_average_ma;
   logic [LEN_W-1:0]       rsp_reply_length;
   logic                   csr_valid        = 1'b0;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index        = '0;
   logic [OFS_W-1:0]       csr_wdata        = '0;

   int   send_idle_pct = 0;
   int   stall_pct     = 0;
   int   hold_left     = 0;
   logic hold_req      = 1'b0;
   logic hold_ack      = 1'b0;

   rail_reply_tracker board;

   rail_current_averaging_monitor DUT (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #10ms;
      $display("Simulation FAILED");
      $finish;
   end

   // receiver: random stalls, or a long hold-off when one is requested
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_req != hold_ack) begin
         hold_ack  <= hold_req;
         hold_left <= HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      monitor_beat_type seen;
      if (!reset && req_valid && !req_stall) begin
         seen.mode           = req_mode;
         seen.code           = req_command_code;
         seen.volt[RAIL_12V] = req_volt_raw_12v;
         seen.volt[RAIL_5V]  = req_volt_raw_5v;
         seen.volt[RAIL_3V3] = req_volt_raw_3v3;
         seen.cur[RAIL_12V]  = req_cur_raw_12v;
         seen.cur[RAIL_5V]   = req_cur_raw_5v;
         seen.cur[RAIL_3V3]  = req_cur_raw_3v3;
         board.note_beat(seen);
      end
      if (!reset && rsp_valid && !rsp_stall)
         board.check_reply(rail_reply_type'{rsp_reply_kind, rsp_rail_fault, rsp_average_ma,
                                            rsp_reply_length});
      if (!reset && csr_valid && csr_ready)
         board.write_reg(csr_index, csr_wdata);
   end

   function automatic logic [ADC_BITS-1:0] rand_adc();
      return ADC_BITS'($urandom);
   endfunction

   function automatic logic [CMD_W-1:0] rand_code();
      return CMD_W'($urandom);
   endfunction

   function automatic monitor_beat_type sample_beat(logic [ADC_BITS-1:0] v12, v5, v3,
                                                    logic [ADC_BITS-1:0] c12, c5, c3,
                                                    logic [CMD_W-1:0] code);
      monitor_beat_type b;
      b.mode           = MODE_SAMPLE;
      b.code           = code;   // ignored on a sample
      b.volt[RAIL_12V] = v12;
      b.volt[RAIL_5V]  = v5;
      b.volt[RAIL_3V3] = v3;
      b.cur[RAIL_12V]  = c12;
      b.cur[RAIL_5V]   = c5;
      b.cur[RAIL_3V3]  = c3;
      return b;
   endfunction

   function automatic monitor_beat_type command_beat(logic [CMD_W-1:0] code);
      monitor_beat_type b;
      b      = sample_beat(rand_adc(), rand_adc(), rand_adc(), rand_adc(), rand_adc(),
                           rand_adc(), code);
      b.mode = MODE_COMMAND;
      return b;
   endfunction

   function automatic logic [ADC_BITS-1:0] near_threshold(logic [THR_W-1:0] thr);
      case ($urandom_range(5))
         0:       return ADC_BITS'(thr - 1'b1);
         1:       return ADC_BITS'(thr);
         2:       return '0;
         3:       return '1;
         default: return ADC_BITS'($urandom);
      endcase
   endfunction

   function automatic monitor_beat_type random_beat(logic [THR_W-1:0] thr);
      monitor_beat_type b;
      int               pick;
      pick   = $urandom_range(99);
      b.code = rand_code();
      for (int r = 0; r < RAILS; r++) begin
         b.volt[r] = near_threshold(thr);
         case ($urandom_range(9))
            0:       b.cur[r] = '0;
            1:       b.cur[r] = '1;
            default: b.cur[r] = rand_adc();
         endcase
      end
      if (pick < 65) begin
         b.mode = MODE_SAMPLE;
      end else begin
         b.mode = MODE_COMMAND;
         // mostly real commands, the rest any code at all
         if (pick < 95) b.code = CMD_W'($urandom_range(CMD_STATUS, CMD_AVG_12V));
      end
      return b;
   endfunction

   // valid stays high from one beat into the next unless the sender idles
   task automatic offer(monitor_beat_type b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_mode         <= b.mode;
      req_command_code <= b.code;
      req_volt_raw_12v <= b.volt[RAIL_12V];
      req_volt_raw_5v  <= b.volt[RAIL_5V];
      req_volt_raw_3v3 <= b.volt[RAIL_3V3];
      req_cur_raw_12v  <= b.cur[RAIL_12V];
      req_cur_raw_5v   <= b.cur[RAIL_5V];
      req_cur_raw_3v3  <= b.cur[RAIL_3V3];
      do @(posedge clock); while (req_stall);
   endtask

   // wait for every reply, then for samples still working through the back end
   task automatic settle();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      while (board.pending_replies.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [OFS_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // junk in the unused upper bits must be dropped
   task automatic configure(logic [THR_W-1:0] thr, logic [SCALE_W-1:0] sc,
                            logic [OFS_W-1:0] ofs);
      write_reg(REG_THRESHOLD, {4'($urandom), thr});
      write_reg(REG_SCALE, {5'($urandom), sc});
      write_reg(REG_OFFSET, ofs);
      write_reg(REG_UNUSED, OFS_W'($urandom));
   endtask

   initial begin
      int idle_plan [4];
      int stall_plan [4];
      int failures;
      idle_plan  = '{0, 82, 0, 24};
      stall_plan = '{0, 0, 82, 24};
      board = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty rails, unknown codes, extremes and the threshold edge
      offer(command_beat(CMD_STATUS));
      offer(command_beat(CMD_AVG_3V3));
      offer(command_beat(CMD_AVG_5V));
      offer(command_beat(CMD_AVG_12V));
      offer(command_beat(8'h00));
      offer(command_beat(8'h05));
      offer(command_beat(8'hFF));
      offer(sample_beat('1, '1, '1, '1, '1, '1, 8'hFF));
      offer(command_beat(CMD_STATUS));
      offer(sample_beat(THRESHOLD_RESET, THRESHOLD_RESET, THRESHOLD_RESET, '0, '0, '0,
                        CMD_STATUS));
      offer(command_beat(CMD_STATUS));
      offer(sample_beat(THRESHOLD_RESET - 1'b1, '1, '1, rand_adc(), rand_adc(), rand_adc(),
                        '0));
      offer(command_beat(CMD_STATUS));
      offer(sample_beat('1, THRESHOLD_RESET - 1'b1, '1, rand_adc(), rand_adc(), rand_adc(),
                        '0));
      offer(command_beat(CMD_STATUS));
      offer(sample_beat('1, '1, THRESHOLD_RESET - 1'b1, rand_adc(), rand_adc(), rand_adc(),
                        '0));
      offer(command_beat(CMD_STATUS));
      offer(command_beat(CMD_AVG_12V));
      offer(command_beat(CMD_AVG_5V));
      offer(command_beat(CMD_AVG_3V3));
      offer(command_beat(CMD_AVG_12V));
      offer(sample_beat('0, '0, '0, rand_adc(), rand_adc(), rand_adc(), rand_code()));
      offer(sample_beat(rand_adc(), rand_adc(), rand_adc(), '0, '1, rand_adc(), rand_code()));
      offer(command_beat(CMD_AVG_3V3));
      settle();

      for (int k = 0; k < 4; k++) begin
         case (k)
            0:       configure('0, '0, '0);
            1:       configure('1, '1, '1);
            2:       configure(THR_W'($urandom), SCALE_W'($urandom), OFS_W'($urandom));
            default: configure(THR_W'($urandom), '1, '0);
         endcase
         send_idle_pct = idle_plan[k];
         stall_pct     = stall_plan[k];
         repeat (RANDOM_PER_PHASE) offer(random_beat(board.threshold));
         settle();
      end

      // back to defaults, then hold replies off so the input side backs up
      configure(THRESHOLD_RESET, SCALE_RESET, OFFSET_RESET);
      send_idle_pct = 0;
      stall_pct     = 0;
      hold_req     <= ~hold_req;
      repeat (PRESSURE_BEATS) offer(random_beat(board.threshold));
      settle();

      failures = board.mismatches + board.pending_replies.size();
      if (board.pending_replies.size() != 0)
         $display("%0d expected replies never arrived", board.pending_replies.size());
      $display("covered %0d samples, %0d status queries, %0d averages, %0d empty reads,",
               board.samples_seen, board.status_asked, board.averages_read, board.empty_reads);
      $display("%0d ignored commands, five register settings and one long reply hold-off",
               board.ignored_cmds);
      if (failures == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
